FILE: sv/cls_pkg.sv
// Shared types and constants for the cycle latency statistics block.
// Used by the controller, the datapath and the top level.
package cls_pkg;

    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] REG_DEADLINE = 2'd0;

    localparam logic [31:0] RNG_SEED = 32'h6D2B79F5;
    localparam logic [31:0] U32_ALL  = 32'hFFFF_FFFF;
    localparam logic [63:0] U64_ALL  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [6:0]  PCT_MED  = 7'd50;
    localparam logic [6:0]  PCT_P95  = 7'd95;

    typedef struct packed {
        logic record_start; // latch sample, update stats, start slot pick
        logic clear;
        logic read_start;   // latch summary, start mean divide and rank pass
    } cls_cmd_t;

    typedef struct packed {
        logic busy;
    } cls_stat_t;

    typedef struct packed {
        logic [31:0] sample_total;
        logic [31:0] mean_cycles;
        logic [31:0] median_cycles;
        logic [31:0] p95_cycles;
        logic [31:0] max_cycles;
        logic [31:0] violation_total;
        logic [31:0] deadline_echo;
    } cls_result_t;

endpackage

FILE: sv/cls_ctrl.sv
// Controller for the cycle latency statistics block: input and output handshake.
// Depends on cls_pkg.
module cls_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cls_pkg::cls_cmd_t cmd,
    input  cls_pkg::cls_stat_t stat
);
    import cls_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REC  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign acc       = in_valid && in_ready;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    case (in_action)
                        ACT_RECORD: begin
                            cmd.record_start = 1'b1;
                            state_next = ST_REC;
                        end
                        ACT_READ: begin
                            cmd.read_start = 1'b1;
                            state_next = ST_RD;
                        end
                        ACT_CLEAR: cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_REC: if (!stat.busy) state_next = ST_IDLE;
            ST_RD:  if (!stat.busy) state_next = ST_OUT;
            ST_OUT: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule

FILE: sv/cls_dp.sv
// Datapath: statistics registers, reservoir memory, serial divider, rank pass.
// Depends on cls_pkg.
module cls_dp #(
    parameter int RESERVOIR_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cls_pkg::cls_cmd_t     cmd,
    output cls_pkg::cls_stat_t    stat,
    input  logic [31:0]           in_sample,
    input  logic [31:0]           deadline,
    output cls_pkg::cls_result_t  result
);
    import cls_pkg::*;

    localparam int AW = $clog2(RESERVOIR_DEPTH);
    localparam int FW = $clog2(RESERVOIR_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(RESERVOIR_DEPTH);
    localparam int PW = FW + 7;
    localparam int RW = PW + 18;
    // The rank divide by 100 is a multiply by ceil(2^24 / 100), exact for these ranks.
    localparam logic [17:0] RECIP_100 = 18'd167773;

    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_DIV   = 4'd1; // 64-bit dividend serial divide
    localparam logic [3:0] P_WR    = 4'd2; // reservoir write, after slot pick once full
    localparam logic [3:0] P_RK0   = 4'd3; // rank multiply
    localparam logic [3:0] P_RK1   = 4'd4; // rank divide by 100
    localparam logic [3:0] P_OA    = 4'd5; // outer read issue
    localparam logic [3:0] P_OB    = 4'd6; // outer data ready, inner read issue
    localparam logic [3:0] P_IC    = 4'd7; // inner compare
    localparam logic [3:0] P_IB    = 4'd8; // inner read data wait

    logic [3:0]  ph_reg, ph_next;
    logic        is_read_reg;

    logic [31:0] seen_reg, late_reg, peak_reg, rng_reg;
    logic [63:0] sum_reg;
    logic [FW-1:0] fill_reg;
    logic [31:0] samp_reg;

    logic [31:0] mem [RESERVOIR_DEPTH];
    logic [31:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;

    // Shared restoring divider.
    logic [63:0] dq_reg;   // dividend shifting into quotient
    logic [32:0] drem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  dcnt_reg;
    logic [32:0] dtrial;

    // Rank selection state.
    logic [31:0] med_reg, p95_reg, cand_reg, mean_reg;
    logic [AW-1:0] oi_reg, ii_reg;
    logic [FW-1:0] lt_reg, le_reg;
    logic [FW-1:0] rk_med_reg, rk_p95_reg;
    logic [PW-1:0] prod_med_reg, prod_p95_reg;
    logic [RW-1:0] rq_med, rq_p95;
    logic [31:0] sfrz_reg, lfrz_reg, pkfrz_reg, dlfrz_reg;

    logic [FW-1:0] nm1;
    logic [63:0] half_sum;

    assign nm1 = fill_reg - FW'(1);
    assign half_sum = (sum_reg > U64_ALL - {33'd0, seen_reg[31:1]}) ? U64_ALL
                    : sum_reg + {33'd0, seen_reg[31:1]};
    assign dtrial = {drem_reg[31:0], dq_reg[63]} - {1'b0, dvs_reg};
    assign stat.busy = (ph_reg != P_IDLE);
    assign rq_med = RW'(prod_med_reg) * RW'(RECIP_100);
    assign rq_p95 = RW'(prod_p95_reg) * RW'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= samp_reg;
        rd_data <= mem[rd_addr];
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = '0;
        rd_addr = oi_reg;
        if (cmd.record_start && fill_reg < DEPTH_F) begin
            wr_en = 1'b0;
        end
        if (ph_reg == P_WR) begin
            if (fill_reg < DEPTH_F) begin
                wr_en = 1'b1;
                wr_addr = fill_reg[AW-1:0];
            end else if (drem_reg[31:0] < 32'(RESERVOIR_DEPTH)) begin
                wr_en = 1'b1;
                wr_addr = drem_reg[AW-1:0];
            end
        end
        if (ph_reg == P_OB || ph_reg == P_IB) rd_addr = ii_reg;
    end

    always_comb begin
        ph_next = ph_reg;
        case (ph_reg)
            P_IDLE: begin
                if (cmd.record_start) ph_next = (fill_reg < DEPTH_F) ? P_WR : P_DIV;
                else if (cmd.read_start) ph_next = P_DIV;
            end
            P_DIV: if (dcnt_reg == 7'd1) ph_next = is_read_reg ? P_RK0 : P_WR;
            P_WR:  ph_next = P_IDLE;
            P_RK0: ph_next = P_RK1;
            P_RK1: ph_next = (fill_reg == '0) ? P_IDLE : P_OA;
            P_OA:  ph_next = P_OB;
            P_OB:  ph_next = P_IB;
            P_IB:  ph_next = P_IC;
            P_IC: begin
                if (ii_reg == nm1[AW-1:0]) begin
                    ph_next = (oi_reg == nm1[AW-1:0]) ? P_IDLE : P_OA;
                end else begin
                    ph_next = P_IB;
                end
            end
            default: ph_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            ph_reg <= P_IDLE;
            seen_reg <= '0;
            late_reg <= '0;
            peak_reg <= '0;
            sum_reg <= '0;
            fill_reg <= '0;
            rng_reg <= RNG_SEED;
        end else begin
            ph_reg <= ph_next;
            if (ph_reg == P_IDLE && cmd.record_start) begin
                logic [31:0] r;
                r = rng_reg;
                r = r ^ (r << 13);
                r = r ^ (r >> 17);
                r = r ^ (r << 5);
                if (seen_reg != U32_ALL) seen_reg <= seen_reg + 32'd1;
                sum_reg <= (sum_reg > U64_ALL - {32'd0, in_sample}) ? U64_ALL
                         : sum_reg + {32'd0, in_sample};
                if (in_sample > peak_reg) peak_reg <= in_sample;
                if (deadline != '0 && in_sample >= deadline && late_reg != U32_ALL)
                    late_reg <= late_reg + 32'd1;
                if (fill_reg == DEPTH_F) rng_reg <= r;
            end
            if (ph_reg == P_WR && fill_reg < DEPTH_F) fill_reg <= fill_reg + FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ph_reg == P_IDLE && cmd.record_start) begin
            logic [31:0] r;
            logic [31:0] cnt;
            r = rng_reg;
            r = r ^ (r << 13);
            r = r ^ (r >> 17);
            r = r ^ (r << 5);
            cnt = (seen_reg != U32_ALL) ? seen_reg + 32'd1 : seen_reg;
            samp_reg <= in_sample;
            is_read_reg <= 1'b0;
            dq_reg <= {r, 32'd0};
            drem_reg <= '0;
            dvs_reg <= cnt;
            dcnt_reg <= 7'd32;
        end
        if (ph_reg == P_IDLE && cmd.read_start) begin
            is_read_reg <= 1'b1;
            dq_reg <= half_sum;
            drem_reg <= '0;
            dvs_reg <= seen_reg;
            dcnt_reg <= (seen_reg == '0) ? 7'd1 : 7'd64;
            sfrz_reg <= seen_reg;
            lfrz_reg <= late_reg;
            pkfrz_reg <= peak_reg;
            dlfrz_reg <= deadline;
            med_reg <= '0;
            p95_reg <= '0;
        end
        if (ph_reg == P_DIV) begin
            dcnt_reg <= dcnt_reg - 7'd1;
            if (!dtrial[32]) begin
                drem_reg <= dtrial;
                dq_reg <= {dq_reg[62:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[31:0], dq_reg[63]};
                dq_reg <= {dq_reg[62:0], 1'b0};
            end
        end
        if (ph_reg == P_RK0) begin
            mean_reg <= (sfrz_reg == '0) ? '0 : dq_reg[31:0];
            prod_med_reg <= PW'(PCT_MED) * PW'(nm1) + PW'(50);
            prod_p95_reg <= PW'(PCT_P95) * PW'(nm1) + PW'(50);
            oi_reg <= '0;
        end
        if (ph_reg == P_RK1) begin
            rk_med_reg <= FW'(rq_med >> 24);
            rk_p95_reg <= FW'(rq_p95 >> 24);
        end
        if (ph_reg == P_OA) begin
            ii_reg <= '0;
            lt_reg <= '0;
            le_reg <= '0;
        end
        if (ph_reg == P_OB) begin
            cand_reg <= rd_data;
        end
        if (ph_reg == P_IC) begin
            logic [FW-1:0] lt_n, le_n;
            lt_n = lt_reg + ((rd_data < cand_reg) ? FW'(1) : FW'(0));
            le_n = le_reg + ((rd_data <= cand_reg) ? FW'(1) : FW'(0));
            lt_reg <= lt_n;
            le_reg <= le_n;
            ii_reg <= ii_reg + AW'(1);
            if (ii_reg == nm1[AW-1:0]) begin
                oi_reg <= oi_reg + AW'(1);
                if (lt_n <= rk_med_reg && rk_med_reg < le_n) med_reg <= cand_reg;
                if (lt_n <= rk_p95_reg && rk_p95_reg < le_n) p95_reg <= cand_reg;
            end
        end
    end

    assign result.sample_total    = sfrz_reg;
    assign result.mean_cycles     = mean_reg;
    assign result.median_cycles   = med_reg;
    assign result.p95_cycles      = p95_reg;
    assign result.max_cycles      = pkfrz_reg;
    assign result.violation_total = lfrz_reg;
    assign result.deadline_echo   = dlfrz_reg;
endmodule

FILE: sv/cycle_latency_statistics.sv
// Cycle latency statistics: once the reservoir is full, a record runs a 32-step
// serial modulo to pick a slot; while filling it writes the next slot directly. A read
// runs the 64-step mean divide and then a rank pass over the n filled entries.
// Clear is done from idle and needs no busy phase. One beat is in flight at a time.
// Reset is synchronous, active low, and clears all statistics and the deadline.
module cycle_latency_statistics #(
    parameter int RESERVOIR_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // action[1:0], sample_cycles[33:2], zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata,   // sample_total, mean, median, p95, max, violations, deadline
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cls_pkg::*;

    logic [31:0] deadline_reg;
    cls_cmd_t    cmd;
    cls_stat_t   stat;
    cls_result_t res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DEADLINE) ? deadline_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) deadline_reg <= '0;
        else if (psel && penable && pwrite && paddr == REG_DEADLINE) deadline_reg <= pwdata;
    end

    cls_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_action(s_tdata[1:0]), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd, .stat
    );

    cls_dp #(.RESERVOIR_DEPTH(RESERVOIR_DEPTH)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_sample(s_tdata[33:2]), .deadline(deadline_reg), .result(res)
    );

    assign m_tdata = {res.deadline_echo, res.violation_total, res.max_cycles,
                      res.p95_cycles, res.median_cycles, res.mean_cycles,
                      res.sample_total};
endmodule
